// ===== hdl/afx_pkg.sv =====
package afx_pkg;

  // Coordinate / coefficient width (Q16.16 words by default)
  localparam int CW          = 32;
  localparam int IDX_W       = 5;
  localparam int STORE_DEPTH = 21;
  localparam int NUM_LANES   = 6;
  localparam int PROD_W      = 2 * CW;
  // three full products plus translation and rounding half never exceed this
  localparam int SUM_W       = 2 * CW + 2;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_POINT  = 3'd1,
    OP_VECTOR = 3'd2,
    OP_NORMAL = 3'd3,
    OP_RAY    = 3'd4
  } op_t;

  typedef logic signed [CW-1:0]     coord_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic s1_ld;   // product stage load enable
    logic s2_ld;   // sum stage load enable
    logic with_t;  // add translation term
  } lane_ctl_t;

endpackage

// ===== hdl/afx_ifs.sv =====
interface afx_in_if;
  import afx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [2:0]             operation;
  logic [IDX_W-1:0]       coeff_index;
  logic signed [CW-1:0]   coeff_value;
  logic signed [CW-1:0]   ax;
  logic signed [CW-1:0]   ay;
  logic signed [CW-1:0]   az;
  logic signed [CW-1:0]   bx;
  logic signed [CW-1:0]   by;
  logic signed [CW-1:0]   bz;

  modport source (
    output valid, operation, coeff_index, coeff_value, ax, ay, az, bx, by, bz,
    input  ready
  );
  modport sink (
    input  valid, operation, coeff_index, coeff_value, ax, ay, az, bx, by, bz,
    output ready
  );
endinterface

interface afx_out_if;
  import afx_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [CW-1:0]   out_ax;
  logic signed [CW-1:0]   out_ay;
  logic signed [CW-1:0]   out_az;
  logic signed [CW-1:0]   out_bx;
  logic signed [CW-1:0]   out_by;
  logic signed [CW-1:0]   out_bz;
  logic                   saturated;

  modport source (
    output valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_ax, out_ay, out_az, out_bx, out_by, out_bz, saturated,
    output ready
  );
endinterface

// ===== hdl/affine_transform_apply_unit.sv =====
// Affine transform unit, signed fixed point (FRAC_BITS fraction bits).
// in_ch carries one beat per operation: a coefficient load (slot and value)
// or a point, vector, normal or ray to transform. out_ch returns one beat per
// transform with the first triple, the ray direction (zero unless ray) and a
// flag set when any output was clamped to 32 bits.
// Loads update the coefficient store at the accepting edge and return no
// beat; the very next transform already sees the new word. Unknown opcodes
// and loads to slots above 20 are dropped without a beat.
// Six lanes (three rows for the first triple, three for the direction) each
// run a multiply stage and a sum stage; a merge stage rounds, clamps and
// registers the result beat.
// A beat passes three stages in turn: product, sum, output register. Throughput:
// one beat per cycle while out_ch is not stalled; each stage has its own valid.
// Receiver stall: stages fill behind the output register; in_ch.ready drops
// only when all three stages hold a transform and out_ch is stalled.
// Reset: pipeline emptied, coefficient store returns to identity for both
// the forward matrix and the inverse 3x3.
module affine_transform_apply_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  afx_in_if.sink           in_ch,
  afx_out_if.source        out_ch
);
  import afx_pkg::*;

  localparam coord_t ONE = coord_t'(1) << FRAC_BITS;
  // identity diagonal slots: 0, 5, 10 forward and 12, 16, 20 inverse
  localparam logic [STORE_DEPTH-1:0] DIAG = 21'b1_0001_0001_0100_0010_0001;

  // coefficient store, flops read at fixed places per lane
  coord_t coef_r [STORE_DEPTH];

  // stage valids and ray tags
  logic s1_v_r, s2_v_r, out_v_r;
  logic s1_v_nxt, s2_v_nxt, out_v_nxt;
  logic s1_ray_r, s2_ray_r;
  logic s1_ray_nxt, s2_ray_nxt;

  logic s1_ld, s2_ld, out_ld;
  logic in_acc;
  logic is_xf, with_t, is_normal, is_ray;
  logic ld_wr;

  lane_ctl_t ctl_a, ctl_b;
  sum_t      sums [NUM_LANES];
  coord_t    res  [NUM_LANES];
  logic      sat;

  // ---------------- handshake: each stage moves when the next has room
  assign out_ld      = !out_v_r || out_ch.ready;
  assign s2_ld       = !s2_v_r || out_ld;
  assign s1_ld       = !s1_v_r || s2_ld;
  assign in_ch.ready = s1_ld;
  assign in_acc      = in_ch.valid && s1_ld;

  // ---------------- opcode decode
  always_comb begin
    is_xf     = 1'b0;
    with_t    = 1'b0;
    is_normal = 1'b0;
    is_ray    = 1'b0;
    unique case (in_ch.operation)
      OP_POINT: begin
        is_xf  = 1'b1;
        with_t = 1'b1;
      end
      OP_VECTOR: begin
        is_xf = 1'b1;
      end
      OP_NORMAL: begin
        is_xf     = 1'b1;
        is_normal = 1'b1;
      end
      OP_RAY: begin
        is_xf  = 1'b1;
        with_t = 1'b1;
        is_ray = 1'b1;
      end
      default: begin
        is_xf = 1'b0;
      end
    endcase
  end

  assign ld_wr = in_acc && (in_ch.operation == OP_LOAD) &&
                 (in_ch.coeff_index < IDX_W'(STORE_DEPTH));

  // ---------------- coefficient store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        coef_r[i] <= DIAG[i] ? ONE : '0;
      end
    end else if (ld_wr) begin
      coef_r[in_ch.coeff_index] <= in_ch.coeff_value;
    end
  end

  // ---------------- valid / tag pipeline
  assign s1_v_nxt   = s1_ld ? (in_acc && is_xf) : s1_v_r;
  assign s1_ray_nxt = s1_ld ? is_ray : s1_ray_r;
  assign s2_v_nxt   = s2_ld ? s1_v_r : s2_v_r;
  assign s2_ray_nxt = s2_ld ? s1_ray_r : s2_ray_r;
  assign out_v_nxt  = out_ld ? s2_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      s1_ray_r <= 1'b0;
      s2_ray_r <= 1'b0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      out_v_r  <= out_v_nxt;
      s1_ray_r <= s1_ray_nxt;
      s2_ray_r <= s2_ray_nxt;
    end
  end

  // ---------------- lanes
  assign ctl_a = '{s1_ld: s1_ld, s2_ld: s2_ld, with_t: with_t};
  assign ctl_b = '{s1_ld: s1_ld, s2_ld: s2_ld, with_t: 1'b0};

  for (genvar r = 0; r < 3; r++) begin : g_row
    coord_t a0, a1, a2;

    // normal uses a column of the inverse, everything else a row of M
    assign a0 = is_normal ? coef_r[12 + r] : coef_r[4*r];
    assign a1 = is_normal ? coef_r[15 + r] : coef_r[4*r + 1];
    assign a2 = is_normal ? coef_r[18 + r] : coef_r[4*r + 2];

    afx_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_a (
      .clk (clk),
      .ctl (ctl_a),
      .c0  (a0),
      .c1  (a1),
      .c2  (a2),
      .t   (coef_r[4*r + 3]),
      .x   (in_ch.ax),
      .y   (in_ch.ay),
      .z   (in_ch.az),
      .sum (sums[r])
    );

    // ray direction: rotation only
    afx_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
      .clk (clk),
      .ctl (ctl_b),
      .c0  (coef_r[4*r]),
      .c1  (coef_r[4*r + 1]),
      .c2  (coef_r[4*r + 2]),
      .t   (coef_r[4*r + 3]),
      .x   (in_ch.bx),
      .y   (in_ch.by),
      .z   (in_ch.bz),
      .sum (sums[r + 3])
    );
  end

  // ---------------- merge: round, clamp, saturation flag, output register
  afx_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk  (clk),
    .ld   (out_ld),
    .ray  (s2_ray_r),
    .sums (sums),
    .res  (res),
    .sat  (sat)
  );

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_ax    = res[0];
  assign out_ch.out_ay    = res[1];
  assign out_ch.out_az    = res[2];
  assign out_ch.out_bx    = res[3];
  assign out_ch.out_by    = res[4];
  assign out_ch.out_bz    = res[5];
  assign out_ch.saturated = sat;

  // ---------------- assertions
  a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && s2_v_r && out_v_r && !out_ch.ready))
    else $error("input stalled while pipeline has room");

  a_load_written: assert property (@(posedge clk) disable iff (!rst_n)
    ld_wr |=> coef_r[$past(in_ch.coeff_index)] == $past(in_ch.coeff_value))
    else $error("coefficient load not written");

  a_no_result_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_xf) |=> !s1_v_r)
    else $error("non-transform beat entered the pipeline");

  a_sum_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_ld) |=> out_v_r)
    else $error("finished sum lost before output register");

endmodule

// ===== hdl/afx_lane.sv =====
module afx_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  afx_pkg::lane_ctl_t ctl,
  input  afx_pkg::coord_t    c0,
  input  afx_pkg::coord_t    c1,
  input  afx_pkg::coord_t    c2,
  input  afx_pkg::coord_t    t,
  input  afx_pkg::coord_t    x,
  input  afx_pkg::coord_t    y,
  input  afx_pkg::coord_t    z,
  output afx_pkg::sum_t      sum
);
  import afx_pkg::*;

  localparam sum_t HALF = sum_t'(1) << (FRAC_BITS - 1);

  prod_t p0_nxt, p1_nxt, p2_nxt, tt_nxt;
  prod_t p0_r, p1_r, p2_r, tt_r;
  sum_t  sum_nxt, sum_r;

  // stage 1: one 32x32 product per coefficient
  assign p0_nxt = prod_t'(c0) * prod_t'(x);
  assign p1_nxt = prod_t'(c1) * prod_t'(y);
  assign p2_nxt = prod_t'(c2) * prod_t'(z);
  assign tt_nxt = ctl.with_t ? (prod_t'(t) <<< FRAC_BITS) : '0;

  // stage 2: sum with rounding half folded in
  assign sum_nxt = sum_t'(p0_r) + sum_t'(p1_r) + sum_t'(p2_r) + sum_t'(tt_r) + HALF;

  always_ff @(posedge clk) begin
    if (ctl.s1_ld) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      tt_r <= tt_nxt;
    end
    if (ctl.s2_ld) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ===== hdl/afx_merge.sv =====
module afx_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            ld,
  input  logic            ray,
  input  afx_pkg::sum_t   sums [afx_pkg::NUM_LANES],
  output afx_pkg::coord_t res  [afx_pkg::NUM_LANES],
  output logic            sat
);
  import afx_pkg::*;

  localparam coord_t MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t MINV = {1'b1, {(CW-1){1'b0}}};

  coord_t res_nxt [NUM_LANES];
  coord_t res_r   [NUM_LANES];
  logic   sat_nxt, sat_r;

  // shift out fraction, clamp, zero direction lanes unless ray
  always_comb begin
    sum_t sh;
    logic fits;
    logic used;
    sat_nxt = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      sh   = sums[i] >>> FRAC_BITS;
      fits = (&sh[SUM_W-1:CW-1]) || !(|sh[SUM_W-1:CW-1]);
      used = (i < 3) || ray;
      if (!used) begin
        res_nxt[i] = '0;
      end else if (fits) begin
        res_nxt[i] = sh[CW-1:0];
      end else begin
        res_nxt[i] = sh[SUM_W-1] ? MINV : MAXV;
      end
      sat_nxt = sat_nxt | (used & !fits);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule
